### hdl/nps_pkg.sv
package nps_pkg;

    // default sizes
    localparam int NUM_LEVELS_DEF = 4;
    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 16;

    // fixed field widths
    localparam int ACTION_W   = 2;
    localparam int LEVEL_W    = 2;
    localparam int STATUS_W   = 2;
    localparam int INDEX_W    = 8;
    localparam int DIST_OUT_W = 33;
    localparam int LC_W       = 3;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // actions
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_LEVEL = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'd1;

    localparam logic [LC_W-1:0]  LEVEL_COUNT_RST = 3'd4;
    localparam logic [THR_W-1:0] THRESHOLD_RST   = 16'd64;

endpackage

### hdl/nps_if.sv
interface nps_in_if #(
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [nps_pkg::ACTION_W-1:0]      action;
    logic [nps_pkg::LEVEL_W-1:0]       level;
    logic                              kind;
    logic signed [COORD_BITS-1:0]      x;
    logic signed [COORD_BITS-1:0]      y;

    modport source (output valid, action, level, kind, x, y, input ready);
    modport sink   (input valid, action, level, kind, x, y, output ready);
endinterface

interface nps_out_if;
    logic                              valid;
    logic                              ready;
    logic [nps_pkg::STATUS_W-1:0]      status;
    logic [nps_pkg::INDEX_W-1:0]       index;
    logic [nps_pkg::DIST_OUT_W-1:0]    min_distance_squared;

    modport source (output valid, status, index, min_distance_squared, input ready);
    modport sink   (input valid, status, index, min_distance_squared, output ready);
endinterface

interface nps_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [nps_pkg::CFG_IDX_W-1:0]     index;
    logic [nps_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/nps_ram.sv
module nps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/nearest_point_search_core.sv
// Point tables with linear nearest-point search. Every level has a vertex and
// a model table of up to MAX_POINTS signed Q12.4 points, held in one RAM with
// a single read port. Add, clear, an unused action, a bad level, a full table
// and a query on an empty table each answer from the pending register through
// the output register. In a query the RAM read port delivers one stored point
// per cycle into the difference, square and compare-select registers, then the
// done state settles the status. The block takes one word at a time; a finished
// answer waits in the output register while the next word is taken. Configuration
// writes are taken at any time and must only come while the block is idle. The
// point RAM needs no clearing pass: only entries below a table's count are read.
module nearest_point_search_core #(
    parameter int NUM_LEVELS = nps_pkg::NUM_LEVELS_DEF,
    parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nps_cfg_if.sink    i_cfg,
    nps_in_if.sink     i_in,
    nps_out_if.source  o_out
);

    localparam int TABLES   = 2 * NUM_LEVELS;
    localparam int TBL_W    = $clog2(TABLES);
    localparam int ENT_W    = $clog2(MAX_POINTS);
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W   = TBL_W + ENT_W;
    localparam int RAM_DEPTH = TABLES << ENT_W;
    localparam int D_W      = COORD_BITS + 1;
    localparam int SQ_W     = 2 * D_W;
    localparam int DIST_W   = SQ_W + 1;
    localparam int THR_W    = nps_pkg::THR_W;
    localparam int THR2_W   = 2 * THR_W;
    localparam int CMP_W    = (DIST_W > THR2_W) ? DIST_W : THR2_W;
    localparam int LC_W     = nps_pkg::LC_W;
    localparam int IDX_W    = nps_pkg::INDEX_W;
    localparam int OUT_DW   = nps_pkg::DIST_OUT_W;
    localparam int ST_W     = nps_pkg::STATUS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [IDX_W-1:0]  index;
        logic [OUT_DW-1:0] distance;
    } t_result;

    logic [1:0]                   r_state;
    logic [LC_W-1:0]              r_level_count;
    logic [THR_W-1:0]             r_thr;
    logic [CNT_W-1:0]             r_counts [TABLES];

    logic [TBL_W-1:0]             r_table;
    logic [CNT_W-1:0]             r_cnt;
    logic signed [COORD_BITS-1:0] r_qx;
    logic signed [COORD_BITS-1:0] r_qy;
    logic [THR2_W-1:0]            r_thr2;
    logic [ENT_W-1:0]             r_rd_idx;
    logic                         r_issue;

    logic                         r_v1, r_v2, r_v3;
    logic                         r_last1, r_last2, r_last3;
    logic [ENT_W-1:0]             r_i1, r_i2, r_i3;
    logic [D_W-1:0]               r_ax, r_ay;
    logic [SQ_W-1:0]              r_sx, r_sy;

    logic [DIST_W-1:0]            r_best;
    logic [ENT_W-1:0]             r_best_idx;
    logic                         r_have;

    logic                         r_pend;
    t_result                      r_pend_res;
    logic                         r_out_valid;
    t_result                      r_out_res;

    logic                         w_in_acc;
    logic                         w_level_ok;
    logic [TBL_W-1:0]             w_table;
    logic [CNT_W-1:0]             w_count;
    logic                         w_full;
    logic                         w_we;
    logic                         w_scan_start;
    logic [ST_W-1:0]              w_imm_status;
    logic [ADDR_W-1:0]            w_waddr;
    logic [ADDR_W-1:0]            w_raddr;
    logic [2*COORD_BITS-1:0]      w_rdata;
    logic                         w_last_issue;
    logic signed [COORD_BITS-1:0] w_rx, w_ry;
    logic signed [D_W-1:0]        w_dx, w_dy;
    logic [DIST_W-1:0]            w_d2;
    logic                         w_take;
    logic                         w_move;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE) && !r_pend;
    assign w_in_acc    = i_in.valid && i_in.ready;

    assign w_level_ok = ({1'b0, i_in.level} < r_level_count)
                        && (32'(i_in.level) < NUM_LEVELS);
    assign w_table    = TBL_W'({i_in.level, i_in.kind});
    assign w_count    = r_counts[w_table];
    assign w_full     = (w_count == CNT_W'(MAX_POINTS));

    assign w_we    = w_in_acc && (i_in.action == nps_pkg::ACT_ADD) && w_level_ok && !w_full;
    assign w_waddr = {w_table, w_count[ENT_W-1:0]};
    assign w_raddr = {r_table, r_rd_idx};

    assign w_scan_start = (i_in.action == nps_pkg::ACT_QUERY) && w_level_ok
                          && (w_count != '0);

    // answer for every word that needs no scan
    always_comb begin
        unique case (i_in.action)
            nps_pkg::ACT_ADD: begin
                if (!w_level_ok) begin
                    w_imm_status = nps_pkg::STAT_BAD_LEVEL;
                end else if (w_full) begin
                    w_imm_status = nps_pkg::STAT_FULL;
                end else begin
                    w_imm_status = nps_pkg::STAT_OK;
                end
            end
            nps_pkg::ACT_QUERY: begin
                if (!w_level_ok) begin
                    w_imm_status = nps_pkg::STAT_BAD_LEVEL;
                end else begin
                    w_imm_status = nps_pkg::STAT_MISS;
                end
            end
            nps_pkg::ACT_CLEAR: begin
                w_imm_status = nps_pkg::STAT_OK;
            end
            nps_pkg::ACT_NONE: begin
                w_imm_status = nps_pkg::STAT_OK;
            end
        endcase
    end

    nps_ram #(
        .WIDTH(2 * COORD_BITS),
        .DEPTH(RAM_DEPTH)
    ) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_in.y, i_in.x}),
        .i_re    (r_issue),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_last_issue = (CNT_W'(r_rd_idx) == (r_cnt - CNT_W'(1)));

    assign w_rx = w_rdata[COORD_BITS-1:0];
    assign w_ry = w_rdata[2*COORD_BITS-1:COORD_BITS];
    assign w_dx = {r_qx[COORD_BITS-1], r_qx} - {w_rx[COORD_BITS-1], w_rx};
    assign w_dy = {r_qy[COORD_BITS-1], r_qy} - {w_ry[COORD_BITS-1], w_ry};

    assign w_d2   = DIST_W'(r_sx) + DIST_W'(r_sy);
    // strict compare keeps the first minimum on ties
    assign w_take = r_v3 && (!r_have || (w_d2 < r_best));

    assign w_move = r_pend && (!r_out_valid || o_out.ready);

    assign o_out.valid                = r_out_valid;
    assign o_out.status               = r_out_res.status;
    assign o_out.index                = r_out_res.index;
    assign o_out.min_distance_squared = r_out_res.distance;

    // scan datapath
    always_ff @(posedge i_clk) begin
        r_i1 <= r_rd_idx;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_ax <= w_dx[D_W-1] ? D_W'(-w_dx) : D_W'(w_dx);
        r_ay <= w_dy[D_W-1] ? D_W'(-w_dy) : D_W'(w_dy);
        r_sx <= SQ_W'(r_ax * r_ax);
        r_sy <= SQ_W'(r_ay * r_ay);
        if (w_take) begin
            r_best     <= w_d2;
            r_best_idx <= r_i3;
        end
        if (w_move) begin
            r_out_res <= r_pend_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_level_count <= nps_pkg::LEVEL_COUNT_RST;
            r_thr         <= nps_pkg::THRESHOLD_RST;
            for (int t = 0; t < TABLES; t++) begin
                r_counts[t] <= '0;
            end
            r_issue     <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_last1     <= 1'b0;
            r_last2     <= 1'b0;
            r_last3     <= 1'b0;
            r_have      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    nps_pkg::CFG_LEVEL_COUNT: r_level_count <= i_cfg.data[LC_W-1:0];
                    nps_pkg::CFG_THRESHOLD:   r_thr         <= i_cfg.data[THR_W-1:0];
                endcase
            end

            // output register
            if (w_move) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // read pipeline
            r_v1    <= r_issue;
            r_last1 <= r_issue && w_last_issue;
            r_v2    <= r_v1;
            r_last2 <= r_last1;
            r_v3    <= r_v2;
            r_last3 <= r_last2;
            if (w_take) begin
                r_have <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_scan_start) begin
                            // hold the answer until the scan ends
                            r_table  <= w_table;
                            r_cnt    <= w_count;
                            r_qx     <= i_in.x;
                            r_qy     <= i_in.y;
                            r_thr2   <= THR2_W'(r_thr) * THR2_W'(r_thr);
                            r_rd_idx <= '0;
                            r_issue  <= 1'b1;
                            r_have   <= 1'b0;
                            r_state  <= S_SCAN;
                        end else begin
                            r_pend              <= 1'b1;
                            r_pend_res.status   <= w_imm_status;
                            r_pend_res.index    <= '0;
                            r_pend_res.distance <= '0;
                        end
                        if (w_we) begin
                            r_counts[w_table] <= w_count + CNT_W'(1);
                        end else if (i_in.action == nps_pkg::ACT_CLEAR) begin
                            for (int t = 0; t < TABLES; t++) begin
                                r_counts[t] <= '0;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        r_rd_idx <= r_rd_idx + ENT_W'(1);
                        if (w_last_issue) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_v3 && r_last3) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_pend              <= 1'b1;
                    r_pend_res.status   <= (CMP_W'(r_best) < CMP_W'(r_thr2))
                                           ? nps_pkg::STAT_OK : nps_pkg::STAT_MISS;
                    r_pend_res.index    <= IDX_W'(r_best_idx);
                    r_pend_res.distance <= OUT_DW'(r_best);
                    r_state             <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/nps_checker.sv
module nps_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [nps_pkg::STATUS_W-1:0]     i_out_status,
    input logic [nps_pkg::INDEX_W-1:0]      i_out_index,
    input logic [nps_pkg::DIST_OUT_W-1:0]   i_out_dist
);

    // a stalled answer stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_status) && $stable(i_out_index) && $stable(i_out_dist))
        else $error("output word changed while stalled");

    // one word in flight: the block busies itself right after taking one
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again before the previous word was answered");

    // rejected words carry no search result
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == nps_pkg::STAT_BAD_LEVEL
                        || i_out_status == nps_pkg::STAT_FULL)
            |-> (i_out_index == '0) && (i_out_dist == '0))
        else $error("rejected word carries a nonzero index or distance");

endmodule

bind nearest_point_search_core nps_checker u_nps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_index  (o_out.index),
    .i_out_dist   (o_out.min_distance_squared)
);
